// ===== rtl/core/tga_rle_pkg.sv =====
// shared types and constants for the tga run-length pixel decoder
// no dependencies; imported by tga_rle_ctrl, tga_rle_dpath and the top level
package tga_rle_pkg;

  // default image size limits
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // fixed field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned CIDX_W  = 2;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned OUT_W   = 72;

  // packet header: top bit marks a repeat packet
  localparam int unsigned HDR_REPEAT_BIT = 7;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_HAS_ALPHA    = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_FLIP_ROWS    = 2'd3;

  // controller states
  typedef enum logic [1:0] {
    ST_RUN,
    ST_EMIT,
    ST_DONE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic restart;
    logic accept_byte;
    logic emit_seg;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pix_complete;
    logic out_free;
    logic seg_last;
    logic seg_done;
  } dp_stat_t;

endpackage

// ===== rtl/core/tga_rle_ctrl.sv =====
// controller state machine of the tga run-length pixel decoder
// depends on tga_rle_pkg; drives commands into tga_rle_dpath
module tga_rle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                cfg_valid,
  input  tga_rle_pkg::dp_stat_t stat,
  output tga_rle_pkg::dp_cmd_t  cmd
);
  import tga_rle_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RUN: begin
        if (in_tvalid && stat.pix_complete) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          if (stat.seg_done) state_nxt = ST_DONE;
          else if (stat.seg_last) state_nxt = ST_RUN;
        end
      end
      ST_DONE: state_nxt = ST_DONE;
      default: state_nxt = ST_RUN;
    endcase
    if (cfg_valid) state_nxt = ST_RUN;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_RUN;
    else        state_r <= state_nxt;
  end

  // outputs
  always_comb begin
    in_tready       = 1'b0;
    cmd.restart     = cfg_valid;
    cmd.accept_byte = 1'b0;
    cmd.emit_seg    = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_tready       = 1'b1;
        cmd.accept_byte = in_tvalid;
      end
      ST_EMIT: cmd.emit_seg = stat.out_free;
      ST_DONE: in_tready = 1'b1;
      default: in_tready = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/tga_rle_dpath.sv =====
// datapath of the tga run-length pixel decoder: config, packet and
// pixel state, row/column position, segment output register; uses tga_rle_pkg
module tga_rle_dpath #(
  parameter int unsigned MAX_WIDTH  = tga_rle_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = tga_rle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tga_rle_pkg::dp_cmd_t                 cmd,
  output tga_rle_pkg::dp_stat_t                stat,
  input  logic [tga_rle_pkg::BYTE_W-1:0]       in_byte,
  input  logic [tga_rle_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [tga_rle_pkg::CFG_W-1:0]        cfg_data,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [tga_rle_pkg::OUT_W-1:0]        out_tdata,
  output logic                                 out_tlast,
  output logic                                 out_tuser
);
  import tga_rle_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW = (CW > BYTE_W) ? CW : BYTE_W;

  // configuration, held clamped to the legal range
  logic [CW-1:0] eff_w_r, eff_w_nxt;
  logic [RW-1:0] eff_h_r, eff_h_nxt;
  logic          has_alpha_r, has_alpha_nxt;
  logic          flip_r, flip_nxt;

  // stream state
  logic              phase_r, phase_nxt;
  logic              is_repeat_r, is_repeat_nxt;
  logic [BYTE_W-1:0] packet_left_r, packet_left_nxt;
  logic [1:0]        byte_idx_r, byte_idx_nxt;
  logic [BYTE_W-1:0] run_left_r, run_left_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic              out_valid_r, out_valid_nxt;

  // payload
  logic [3*BYTE_W-1:0] pix_r, pix_nxt;
  logic [BYTE_W-1:0]   alpha_r, alpha_nxt;
  logic [BYTE_W-1:0]   o_red_r, o_green_r, o_blue_r, o_alpha_r, o_len_r;
  logic [POS_W-1:0]    o_row_r, o_col_r;
  logic                o_last_r, o_done_r;

  // segment arithmetic
  logic [CW-1:0]     room;
  logic [LW-1:0]     take_lw;
  logic [BYTE_W-1:0] take;
  logic [CW:0]       col_end;
  logic              row_wrap;
  logic [RW:0]       row_inc;
  logic              seg_done;
  logic              seg_last;
  logic [RW-1:0]     drow;
  logic [1:0]        last_idx;
  logic [BYTE_W-1:0] hdr_count;

  always_comb begin
    room     = eff_w_r - col_r;
    take_lw  = (LW'(run_left_r) <= LW'(room)) ? LW'(run_left_r) : LW'(room);
    take     = take_lw[BYTE_W-1:0];
    col_end  = (CW+1)'(col_r) + (CW+1)'(take);
    row_wrap = (col_end == (CW+1)'(eff_w_r));
    row_inc  = (RW+1)'(row_r) + (RW+1)'(1);
    seg_done = row_wrap && (row_inc == (RW+1)'(eff_h_r));
    seg_last = (run_left_r == take) || seg_done;
    drow     = flip_r ? (eff_h_r - RW'(1) - row_r) : row_r;
    last_idx = has_alpha_r ? 2'd3 : 2'd2;
    // raw: header+1, repeat: header-127; both are low seven bits plus one
    hdr_count = {1'b0, in_byte[HDR_REPEAT_BIT-1:0]} + BYTE_W'(1);
  end

  // status to controller
  always_comb begin
    stat.pix_complete = phase_r && (byte_idx_r == last_idx);
    stat.out_free     = !out_valid_r || out_tready;
    stat.seg_last     = seg_last;
    stat.seg_done     = seg_done;
  end

  // configuration writes
  always_comb begin
    eff_w_nxt     = eff_w_r;
    eff_h_nxt     = eff_h_r;
    has_alpha_nxt = has_alpha_r;
    flip_nxt      = flip_r;
    if (cmd.restart) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          if (cfg_data < CFG_W'(4))               eff_w_nxt = CW'(4);
          else if (32'(cfg_data) > MAX_WIDTH)     eff_w_nxt = CW'(MAX_WIDTH);
          else                                    eff_w_nxt = CW'(cfg_data);
        end
        CFG_IMAGE_HEIGHT: begin
          if (cfg_data == '0)                     eff_h_nxt = RW'(1);
          else if (32'(cfg_data) > MAX_HEIGHT)    eff_h_nxt = RW'(MAX_HEIGHT);
          else                                    eff_h_nxt = RW'(cfg_data);
        end
        CFG_HAS_ALPHA: has_alpha_nxt = cfg_data[0];
        CFG_FLIP_ROWS: flip_nxt      = cfg_data[0];
        default:       flip_nxt      = flip_r;
      endcase
    end
  end

  // packet, pixel and position tracking
  always_comb begin
    phase_nxt       = phase_r;
    is_repeat_nxt   = is_repeat_r;
    packet_left_nxt = packet_left_r;
    byte_idx_nxt    = byte_idx_r;
    run_left_nxt    = run_left_r;
    col_nxt         = col_r;
    row_nxt         = row_r;
    pix_nxt         = pix_r;
    alpha_nxt       = alpha_r;
    if (cmd.restart) begin
      phase_nxt       = 1'b0;
      is_repeat_nxt   = 1'b0;
      packet_left_nxt = '0;
      byte_idx_nxt    = '0;
      run_left_nxt    = '0;
      col_nxt         = '0;
      row_nxt         = '0;
    end else if (cmd.accept_byte) begin
      if (!phase_r) begin
        // packet header
        is_repeat_nxt   = in_byte[HDR_REPEAT_BIT];
        packet_left_nxt = hdr_count;
        byte_idx_nxt    = '0;
        phase_nxt       = 1'b1;
      end else begin
        case (byte_idx_r)
          2'd0:    pix_nxt[BYTE_W-1:0]          = in_byte;
          2'd1:    pix_nxt[2*BYTE_W-1:BYTE_W]   = in_byte;
          2'd2:    pix_nxt[3*BYTE_W-1:2*BYTE_W] = in_byte;
          default: alpha_nxt                    = in_byte;
        endcase
        if (byte_idx_r == last_idx) begin
          // pixel complete: load the run and retire it from the packet
          byte_idx_nxt = '0;
          if (is_repeat_r) begin
            run_left_nxt    = packet_left_r;
            packet_left_nxt = '0;
          end else begin
            run_left_nxt    = BYTE_W'(1);
            packet_left_nxt = packet_left_r - BYTE_W'(1);
          end
          phase_nxt = (packet_left_nxt != '0);
        end else begin
          byte_idx_nxt = byte_idx_r + 2'd1;
        end
      end
    end else if (cmd.emit_seg) begin
      run_left_nxt = run_left_r - take;
      if (row_wrap) begin
        col_nxt = '0;
        row_nxt = RW'(row_inc);
      end else begin
        col_nxt = CW'(col_end);
      end
    end
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit_seg)    out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // control and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r       <= CW'(4);
      eff_h_r       <= RW'(1);
      has_alpha_r   <= 1'b0;
      flip_r        <= 1'b0;
      phase_r       <= 1'b0;
      is_repeat_r   <= 1'b0;
      packet_left_r <= '0;
      byte_idx_r    <= '0;
      run_left_r    <= '0;
      col_r         <= '0;
      row_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      eff_w_r       <= eff_w_nxt;
      eff_h_r       <= eff_h_nxt;
      has_alpha_r   <= has_alpha_nxt;
      flip_r        <= flip_nxt;
      phase_r       <= phase_nxt;
      is_repeat_r   <= is_repeat_nxt;
      packet_left_r <= packet_left_nxt;
      byte_idx_r    <= byte_idx_nxt;
      run_left_r    <= run_left_nxt;
      col_r         <= col_nxt;
      row_r         <= row_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // pixel and segment payload
  always_ff @(posedge clk) begin
    pix_r   <= pix_nxt;
    alpha_r <= alpha_nxt;
    if (cmd.emit_seg) begin
      o_red_r   <= pix_r[3*BYTE_W-1:2*BYTE_W];
      o_green_r <= pix_r[2*BYTE_W-1:BYTE_W];
      o_blue_r  <= pix_r[BYTE_W-1:0];
      o_alpha_r <= has_alpha_r ? alpha_r : '0;
      o_row_r   <= POS_W'(drow);
      o_col_r   <= POS_W'(col_r);
      o_len_r   <= take;
      o_last_r  <= seg_last;
      o_done_r  <= seg_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {8'h00, o_len_r, o_col_r, o_row_r, o_alpha_r,
                       o_blue_r, o_green_r, o_red_r};
  assign out_tlast  = o_last_r;
  assign out_tuser  = o_done_r;

  // checks
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < eff_w_r)
    else $error("column position reached row width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= eff_h_r)
    else $error("row position beyond image height");

  a_emit_has_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_seg |-> (run_left_r != '0) && (take != '0))
    else $error("segment emitted with empty run");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_seg && seg_done |=> out_tlast && out_tuser)
    else $error("final image segment not marked last");

endmodule

// ===== rtl/core/tga_rle_pixel_decoder_top.sv =====
// top level of the tga run-length pixel decoder
// depends on tga_rle_pkg, tga_rle_ctrl and tga_rle_dpath
//
//  channel | dir | beat fields
//  in_     | in  | tdata[7:0] data_byte
//  out_    | out | tdata: red, green, blue, alpha, dest_row, start_col, seg_len;
//          |     | tlast last, tuser image_done
//  cfg_    | in  | cfg_index register, cfg_data value (always ready)
//
// a header byte or a non-final pixel byte is taken in the run state without a stall
// the final byte of a pixel is followed by the segments it makes
//   (one for a raw pixel, one per row touched for a repeat run), each emitted
//   only when the output register is empty or ready; in_tready is low meanwhile
// a segment waits in the output register while input beats go on
// reset and any cfg write restart decoding at the first packet header
module tga_rle_pixel_decoder_top #(
  parameter int unsigned MAX_WIDTH  = tga_rle_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = tga_rle_pkg::MAX_HEIGHT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tdata: [7:0] data_byte
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tga_rle_pkg::BYTE_W-1:0]   in_tdata,
  // tdata: [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
  //   [43:32] dest_row, [55:44] start_col, [63:56] seg_len, [71:64] zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tga_rle_pkg::OUT_W-1:0]    out_tdata,
  output logic                             out_tlast,
  // tuser: [0] image_done
  output logic                             out_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tga_rle_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [tga_rle_pkg::CFG_W-1:0]    cfg_data
);
  import tga_rle_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // register writes are taken at once
  assign cfg_ready = 1'b1;

  // controller
  tga_rle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  tga_rle_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_tdata),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
